// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the packet compressor.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A property that must hold at every rising clock edge outside reset.
`define DBPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define DBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/dbpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet compressor package
// Types, constants and helper functions shared by the compressor modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dbpc_pkg;
    localparam int MaxPacketBytes = 32;
    localparam int LEN_W          = 6;
    localparam int CNT_W          = 3;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [LEN_W-1:0] PACKET_LENGTH_RESET     = 6'd32;
    localparam logic [CNT_W-1:0] KEYFRAME_INTERVAL_RESET = 3'd7;

    // Configuration register indexes.
    localparam logic REG_PACKET_LENGTH     = 1'b0;
    localparam logic REG_KEYFRAME_INTERVAL = 1'b1;

    // Delta form codes as carried in the header.
    localparam logic [1:0] DT_NONE     = 2'd0;
    localparam logic [1:0] DT_BYTEWISE = 2'd1;
    localparam logic [1:0] DT_PAIRS    = 2'd2;
    localparam logic [1:0] DT_FULL     = 2'd3;

    // One completed packet handed from the front to the back.
    typedef struct packed {
        logic [LEN_W-1:0] n;
        logic [CNT_W-1:0] counter;
    } t_desc;

    // Zigzag code of a two's complement byte.
    function automatic logic [7:0] zigzag(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ {8{x[7]}};
    endfunction

    function automatic logic [3:0] ones8(input logic [7:0] x);
        logic [3:0] s;
        s = 4'd0;
        for (int b = 0; b < 8; b++) begin
            s = s + {3'd0, x[b]};
        end
        return s;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/dbpc_in_if.sv -----
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel that carries one byte of a sample packet per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface dbpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dbpc_out_if.sv -----
// ----------------------------------------------------------------------------
// Output byte channel
// Valid/ready channel that carries one byte of a compressed packet per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface dbpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/delta_bitmap_packet_compressor_unit.sv -----
// ----------------------------------------------------------------------------
// Delta bitmap packet compressor
// Compresses fixed-length sample packets with delta, zigzag and zero bitmap.
// ----------------------------------------------------------------------------
// Usage. Bytes of a sample packet arrive one per request on i_in. When the
// last byte of a packet (packet_length bytes) is taken, the packet goes to
// the back end, which emits a header byte and the payload on o_out; the
// final byte of each compressed packet carries last_byte.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// while the block is idle; index 0 is packet_length, index 1 is
// keyframe_interval.
// Timing. Input bytes are taken one per cycle while the front end is not
// stalled. After the last byte of a packet the back end pulls the packet
// from the queue (IDLE), scans it (SCAN, one byte per cycle through the
// three delta forms) and decides (DECIDE) before it loads the header. The
// length and map bytes then follow at one per cycle while the receiver is
// ready, and every payload byte passes through a read (FETCH), then the
// load (DATA); with bitmap packing a skipped zero byte also passes through
// both states. The front end stalls from the last byte of a packet to the
// end of its scan, after which collection overlaps with emission.
// Reset clears the previous packet to zeros, the sample counter and the
// byte index. If the receiver stalls, the output register holds its byte
// and the back end waits; the front end keeps filling until it needs the
// back end again.
// ----------------------------------------------------------------------------
`default_nettype none
module delta_bitmap_packet_compressor_unit
    import dbpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MaxPacketBytes
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    dbpc_in_if.sink         i_in,
    dbpc_out_if.source      o_out,
    input  wire             i_cfg_wr_en,
    input  wire             i_cfg_index,
    input  wire [LEN_W-1:0] i_cfg_data
);
    localparam int IDX_W = $clog2(MAX_PACKET_BYTES);

    logic [LEN_W-1:0] r_packet_length;
    logic [CNT_W-1:0] r_keyframe_interval;

    logic             w_push;
    t_desc            w_push_desc;
    t_desc            w_head_desc;
    logic             w_pop;
    logic             w_empty;
    logic             w_full;
    logic             w_release;
    logic [IDX_W-1:0] w_rd_addr;
    logic [7:0]       w_rd_data;

    // Configuration registers; the register index decodes both entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_length     <= PACKET_LENGTH_RESET;
            r_keyframe_interval <= KEYFRAME_INTERVAL_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PACKET_LENGTH: begin
                    r_packet_length <= i_cfg_data;
                end
                REG_KEYFRAME_INTERVAL: begin
                    r_keyframe_interval <= i_cfg_data[CNT_W-1:0];
                end
                default: begin
                    r_packet_length <= r_packet_length;
                end
            endcase
        end
    end

    // Front end: collects bytes and counts samples.
    dbpc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in               (i_in),
        .i_packet_length    (r_packet_length),
        .i_keyframe_interval(r_keyframe_interval),
        .o_push             (w_push),
        .o_desc             (w_push_desc),
        .i_full             (w_full),
        .i_release          (w_release),
        .i_rd_addr          (w_rd_addr),
        .o_rd_data          (w_rd_data)
    );

    // Queue of completed packets awaiting the back end.
    dbpc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_desc (w_push_desc),
        .i_pop  (w_pop),
        .o_desc (w_head_desc),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    // Back end: scores the forms and emits the compressed packet.
    dbpc_back #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_desc   (w_head_desc),
        .o_pop    (w_pop),
        .o_rd_addr(w_rd_addr),
        .i_rd_data(w_rd_data),
        .o_release(w_release),
        .o_out    (o_out)
    );
endmodule
`default_nettype wire

// ----- rtl/core/dbpc_front.sv -----
// ----------------------------------------------------------------------------
// Packet compressor front end
// Collects packet bytes, tracks the sample counter and hands off packets.
// ----------------------------------------------------------------------------
`default_nettype none
module dbpc_front
    import dbpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MaxPacketBytes
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dbpc_in_if.sink          i_in,
    input  wire [LEN_W-1:0]  i_packet_length,
    input  wire [CNT_W-1:0]  i_keyframe_interval,
    output logic             o_push,
    output t_desc            o_desc,
    input  wire              i_full,
    input  wire              i_release,
    input  wire [$clog2(MAX_PACKET_BYTES)-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);
    localparam int IDX_W = $clog2(MAX_PACKET_BYTES);

    logic [7:0]       r_cur [MAX_PACKET_BYTES];
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_counter;
    logic             r_busy;

    logic [LEN_W-1:0] n_len;
    logic [CNT_W-1:0] n_intv;
    logic [LEN_W:0]   n_next_idx;
    logic             n_accept;
    logic             n_complete;
    logic [CNT_W:0]   n_cnt_inc;

    always_comb begin
        if (i_packet_length == '0) begin
            n_len = LEN_W'(1);
        end else if (i_packet_length > LEN_W'(MAX_PACKET_BYTES)) begin
            n_len = LEN_W'(MAX_PACKET_BYTES);
        end else begin
            n_len = i_packet_length;
        end
        n_intv     = (i_keyframe_interval == '0) ? CNT_W'(1) : i_keyframe_interval;
        n_next_idx = (LEN_W+1)'(r_idx) + (LEN_W+1)'(1);
        n_complete = !(n_next_idx < {1'b0, n_len});
        n_accept   = i_in.valid && i_in.ready;
        n_cnt_inc  = {1'b0, r_counter} + (CNT_W+1)'(1);
    end

    assign i_in.ready = !r_busy && !i_full;
    assign o_push     = n_accept && n_complete;
    assign o_desc     = '{n: n_len, counter: r_counter};
    assign o_rd_data  = r_cur[i_rd_addr];

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_cur[r_idx] <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_counter <= '0;
            r_busy    <= 1'b0;
        end else begin
            if (n_accept) begin
                if (n_complete) begin
                    r_idx     <= '0;
                    r_busy    <= 1'b1;
                    r_counter <= (n_cnt_inc >= {1'b0, n_intv}) ? '0 : n_cnt_inc[CNT_W-1:0];
                end else begin
                    r_idx <= n_next_idx[IDX_W-1:0];
                end
            end else if (i_release) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/dbpc_queue.sv -----
// ----------------------------------------------------------------------------
// Packet descriptor queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dbpc_queue
    import dbpc_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_desc  i_desc,
    input  wire    i_pop,
    output t_desc  o_desc,
    output logic   o_empty,
    output logic   o_full
);
    t_desc      r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_desc  = r_mem[r_rp];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `DBPC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `DBPC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")
endmodule
`default_nettype wire

// ----- rtl/core/dbpc_back.sv -----
// ----------------------------------------------------------------------------
// Packet compressor back end
// Scores the delta forms, picks the packing and streams out the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dbpc_back
    import dbpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MaxPacketBytes
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  t_desc            i_desc,
    output logic             o_pop,
    output logic [$clog2(MAX_PACKET_BYTES)-1:0] o_rd_addr,
    input  wire [7:0]        i_rd_data,
    output logic             o_release,
    dbpc_out_if.source       o_out
);
    localparam int IDX_W     = $clog2(MAX_PACKET_BYTES);
    localparam int SUM_W     = $clog2(MAX_PACKET_BYTES * 8 + 1);
    localparam int NZ_W      = $clog2(MAX_PACKET_BYTES + 1);
    localparam int MAP_BYTES = (MAX_PACKET_BYTES + 7) / 8;
    localparam int MAP_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SCAN   = 8'b00000010,
        ST_DECIDE = 8'b00000100,
        ST_HDR    = 8'b00001000,
        ST_LEN    = 8'b00010000,
        ST_MAP    = 8'b00100000,
        ST_DATA   = 8'b01000000,
        ST_FETCH  = 8'b10000000
    } t_state;

    t_state r_state;

    logic [7:0]            r_prev [MAX_PACKET_BYTES];
    logic [7:0]            r_work [4][MAX_PACKET_BYTES];
    logic [MAX_PACKET_BYTES-1:0] r_zero [4];
    logic [SUM_W-1:0]      r_sum [4];
    logic [NZ_W-1:0]       r_nz [4];
    logic [IDX_W-1:0]      r_idx;
    logic [LEN_W-1:0]      r_n;
    logic [CNT_W-1:0]      r_counter;
    logic                  r_b2;
    logic                  r_b3;
    logic [1:0]            r_sel;
    logic                  r_bitmap;
    logic [NZ_W-1:0]       r_left;
    logic [MAP_W-1:0]      r_k;
    logic [MAP_W:0]        r_map_last;
    logic                  r_ovalid;
    logic [7:0]            r_obyte;
    logic                  r_olast;
    logic [7:0]            r_wbyte;

    logic [7:0] n_c;
    logic [7:0] n_p;
    logic [7:0] n_d [4];
    logic [8:0] n_s2;
    logic [8:0] n_s3;
    logic       n_b2_in;
    logic [1:0] n_sel;
    logic [LEN_W:0] n_map_size;
    logic [7:0] n_bm_size;
    logic       n_can_load;
    logic       n_emit;
    logic [7:0] n_map_byte;
    logic [MAP_W+2:0] n_pos;

    assign o_rd_addr = r_idx;
    assign n_c       = i_rd_data;
    assign n_p       = r_prev[r_idx];
    assign n_can_load = !r_ovalid || o_out.ready;
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign o_release = (r_state == ST_SCAN) && (r_idx == '0);

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.last_byte = r_olast;

    always_comb begin
        n_b2_in = !r_idx[0] && ((LEN_W+1)'(r_idx) + (LEN_W+1)'(1) < {1'b0, r_n}) && r_b2;
        n_s2    = {1'b0, n_c} - {1'b0, n_p} - {8'd0, n_b2_in};
        n_s3    = {1'b0, n_c} - {1'b0, n_p} - {8'd0, r_b3};
        n_d[0]  = n_c;
        n_d[1]  = zigzag(n_c - n_p);
        n_d[2]  = zigzag(n_s2[7:0]);
        n_d[3]  = zigzag(n_s3[7:0]);

        n_sel = DT_NONE;
        if (r_counter != '0) begin
            if (r_sum[1] < r_sum[0]) begin
                n_sel = DT_BYTEWISE;
            end
            if (r_sum[2] < r_sum[n_sel]) begin
                n_sel = DT_PAIRS;
            end
            if (r_sum[3] < r_sum[n_sel]) begin
                n_sel = DT_FULL;
            end
        end
        n_map_size = ({1'b0, r_n} + (LEN_W+1)'(7)) >> 3;
        n_bm_size  = 8'd1 + 8'(n_map_size) + 8'(r_nz[n_sel]);

        n_map_byte = 8'd0;
        n_pos      = '0;
        for (int b = 0; b < 8; b++) begin
            n_pos = {r_k, 3'(b)};
            if ({1'b0, n_pos} < (MAP_W+4)'(MAX_PACKET_BYTES)) begin
                n_map_byte[7-b] = r_zero[r_sel][n_pos[IDX_W-1:0]];
            end
        end

        // A byte goes into the output register in this cycle.
        case (r_state)
            ST_HDR, ST_LEN, ST_MAP: begin
                n_emit = n_can_load;
            end
            ST_DATA: begin
                n_emit = n_can_load && !(r_bitmap && r_wbyte == 8'd0);
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // Previous packet and per-form working copies.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
                r_prev[i] <= 8'd0;
            end
        end else if (r_state == ST_SCAN) begin
            r_prev[r_idx] <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            for (int f = 0; f < 4; f++) begin
                r_work[f][r_idx] <= n_d[f];
            end
        end
    end

    // Registered read of the chosen form at the payload index.
    always_ff @(posedge i_clk) begin
        r_wbyte <= r_work[r_sel][r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (n_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_n       <= i_desc.n;
                        r_counter <= i_desc.counter;
                        r_idx     <= IDX_W'(i_desc.n - LEN_W'(1));
                        r_b2      <= 1'b0;
                        r_b3      <= 1'b0;
                        for (int f = 0; f < 4; f++) begin
                            r_sum[f]  <= '0;
                            r_nz[f]   <= '0;
                            r_zero[f] <= '0;
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    for (int f = 0; f < 4; f++) begin
                        r_sum[f] <= r_sum[f] + SUM_W'(ones8(n_d[f]));
                        if (n_d[f] == 8'd0) begin
                            r_zero[f][r_idx] <= 1'b1;
                        end else begin
                            r_nz[f] <= r_nz[f] + NZ_W'(1);
                        end
                    end
                    if (r_idx[0]) begin
                        r_b2 <= n_s2[8];
                    end
                    r_b3 <= n_s3[8];
                    if (r_idx == '0) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                ST_DECIDE: begin
                    r_sel      <= n_sel;
                    r_bitmap   <= n_bm_size < 8'(r_n);
                    r_left     <= r_nz[n_sel];
                    r_map_last <= n_map_size[MAP_W:0] - (MAP_W+1)'(1);
                    r_state    <= ST_HDR;
                end
                ST_HDR: begin
                    if (n_can_load) begin
                        r_obyte  <= {2'b00, r_bitmap, r_sel, r_counter};
                        r_olast  <= 1'b0;
                        r_idx    <= '0;
                        r_k      <= '0;
                        r_state  <= r_bitmap ? ST_LEN : ST_FETCH;
                    end
                end
                ST_LEN: begin
                    if (n_can_load) begin
                        r_obyte  <= 8'(r_n);
                        r_olast  <= 1'b0;
                        r_state  <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    if (n_can_load) begin
                        r_obyte  <= n_map_byte;
                        r_olast  <= ({1'b0, r_k} == r_map_last) && (r_left == '0);
                        if ({1'b0, r_k} == r_map_last) begin
                            r_state <= (r_left == '0) ? ST_IDLE : ST_FETCH;
                        end else begin
                            r_k <= r_k + MAP_W'(1);
                        end
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_DATA;
                end
                ST_DATA: begin
                    if (r_bitmap && r_wbyte == 8'd0) begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= ST_FETCH;
                    end else if (n_can_load) begin
                        r_obyte  <= r_wbyte;
                        r_left   <= r_left - NZ_W'(1);
                        if (r_bitmap ? (r_left == NZ_W'(1))
                                     : ((LEN_W+1)'(r_idx) + (LEN_W+1)'(1) == {1'b0, r_n})) begin
                            r_olast <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_olast <= 1'b0;
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `DBPC_ASSERT_NEXT(a_scan_to_decide, i_clk, i_rst_n, o_release, r_state == ST_DECIDE, "scan did not end in decide")
    `DBPC_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state != ST_SCAN) || ((LEN_W+1)'(r_idx) < {1'b0, r_n}), "scan index beyond packet")
endmodule
`default_nettype wire

// ----- sim/delta_bitmap_packet_compressor_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet compressor testbench
// Feeds sample packets through the input channel, predicts every compressed
// byte with a behavioral model of the delta, zigzag and zero-bitmap scheme,
// and checks the output channel in order under random gaps and stalls.
// ----------------------------------------------------------------------------
module delta_bitmap_packet_compressor_unit_tb;
    import dbpc_pkg::*;

    // One compressed byte as it should appear on the output channel.
    typedef struct {
        logic [7:0] val;
        logic       last;
    } t_out_byte;

    // Ways of filling a packet.
    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RAND, FILL_NEAR,
                      FILL_SPARSE} t_fill;

    // One row of the directed part: the registers to use, how to fill the
    // packet, and a header typed in where it is obvious.
    typedef struct {
        int         len_cfg;
        int         int_cfg;
        t_fill      fill;
        bit         hdr_known;
        logic [7:0] hdr;
    } t_row;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int RANDOM_BYTES   = 220;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [LEN_W-1:0] cfg_data = '0;

    dbpc_in_if  in_ch();
    dbpc_out_if out_ch();

    delta_bitmap_packet_compressor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the compressor state.
    // ------------------------------------------------------------------
    logic [7:0] prev_pkt [MaxPacketBytes];
    logic [7:0] cur_pkt  [MaxPacketBytes];
    int         fill_idx;
    int         sample_cnt;
    int         len_reg;
    int         interval_reg;

    t_out_byte  pending_bytes[$];
    int         hdr_pos;       // queue slot of the newest predicted header
    bit         pkt_done;      // the last predicted byte closed a packet

    int fail_count  = 0;
    int bytes_in    = 0;
    int bytes_out   = 0;
    int packets_out = 0;
    int bitmap_pkts = 0;
    int delta_seen [4];

    function automatic logic [7:0] zz8(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ {8{x[7]}};
    endfunction

    function automatic int eff_length();
        if (len_reg == 0) return 1;
        if (len_reg > MaxPacketBytes) return MaxPacketBytes;
        return len_reg;
    endfunction

    // Store one accepted byte and, when it closes the packet, predict the
    // whole compressed packet into the queue of pending bytes.
    task automatic predict_packet_byte(input logic [7:0] b);
        int n, span, best, score, k, i, map_bytes, nz, pos, size, sub;
        logic [1:0] dtype;
        logic [7:0] work [MaxPacketBytes];
        logic [7:0] diff [MaxPacketBytes];
        logic [7:0] pay  [MaxPacketBytes];
        logic [15:0] d16;
        logic [7:0] hdr;
        bit borrow;
        n = eff_length();
        span = (interval_reg == 0) ? 1 : interval_reg;
        pkt_done = 1'b0;
        if (fill_idx >= MaxPacketBytes) fill_idx = 0;
        cur_pkt[fill_idx] = b;
        if (fill_idx + 1 < n) begin
            fill_idx++;
            return;
        end
        fill_idx = 0;
        dtype = DT_NONE;
        for (i = 0; i < n; i++) work[i] = cur_pkt[i];
        if (sample_cnt[2:0] != 3'd0) begin
            best = 0;
            for (i = 0; i < n; i++) best += $countones(cur_pkt[i]);
            for (k = 1; k <= 3; k++) begin
                if (k == 1) begin
                    for (i = 0; i < n; i++) diff[i] = zz8(cur_pkt[i] - prev_pkt[i]);
                end else if (k == 2) begin
                    for (i = 0; i < n; i += 2) begin
                        if (i + 1 < n) begin
                            d16 = {cur_pkt[i], cur_pkt[i+1]} - {prev_pkt[i], prev_pkt[i+1]};
                            diff[i]   = zz8(d16[15:8]);
                            diff[i+1] = zz8(d16[7:0]);
                        end else begin
                            diff[i] = zz8(cur_pkt[i] - prev_pkt[i]);
                        end
                    end
                end else begin
                    borrow = 1'b0;
                    for (i = n - 1; i >= 0; i--) begin
                        sub = prev_pkt[i] + borrow;
                        diff[i] = zz8(8'(cur_pkt[i] - sub));
                        borrow = (cur_pkt[i] < sub);
                    end
                end
                score = 0;
                for (i = 0; i < n; i++) score += $countones(diff[i]);
                if (score < best) begin
                    best = score;
                    dtype = 2'(k);
                    for (i = 0; i < n; i++) work[i] = diff[i];
                end
            end
        end
        hdr = {2'b00, 1'b0, dtype, sample_cnt[2:0]};
        for (i = 0; i < n; i++) pay[i] = work[i];
        size = n;
        map_bytes = (n + 7) / 8;
        nz = 0;
        for (i = 0; i < n; i++) if (work[i] != 8'd0) nz++;
        if (1 + map_bytes + nz < n) begin
            pos = 1 + map_bytes;
            for (i = 0; i < n; i++) pay[i] = 8'd0;
            pay[0] = 8'(n);
            for (i = 0; i < n; i++) begin
                if (work[i] == 8'd0) begin
                    pay[1 + (i >> 3)] |= 8'h80 >> (i & 7);
                end else begin
                    pay[pos] = work[i];
                    pos++;
                end
            end
            size = pos;
            hdr[5] = 1'b1;
            bitmap_pkts++;
        end
        delta_seen[dtype]++;
        hdr_pos = pending_bytes.size();
        pending_bytes.push_back('{hdr, 1'b0});
        for (i = 0; i < size; i++) pending_bytes.push_back('{pay[i], i + 1 == size});
        for (i = 0; i < n; i++) prev_pkt[i] = cur_pkt[i];
        sample_cnt = (sample_cnt + 1 >= span) ? 0 : (sample_cnt + 1) & 7;
        pkt_done = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, with stretches where the receiver is
    // always ready. Bytes are checked at the falling edge, where both the
    // block's outputs and our ready are settled, so the check matches the
    // request taken at the following rising edge.
    // ------------------------------------------------------------------
    int  stall_left = 0;
    int  cycle_no = 0;
    bit  quiet_phase;
    int  idle_cycles = 0;

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n || quiet_phase) begin
            out_ch.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Alternate noisy and quiet stretches.
    assign quiet_phase = ((cycle_no / 400) % 3) == 2;

    always @(negedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            bytes_out++;
            if (out_ch.last_byte) packets_out++;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output byte, expected none, actual %02h last %0b",
                         $time, out_ch.out_byte, out_ch.last_byte);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (out_ch.out_byte !== want.val) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.val, out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.last_byte !== want.last) begin
                    $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                             $time, want.last, out_ch.last_byte);
                    fail_count++;
                end
            end
        end
        // Watchdog on cycles where no request moves on either channel.
        if (i_rst_n && ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d bytes outstanding",
                     $time, pending_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Send one byte. The sender may first idle for a random gap; the request
    // is held until ready is seen high before a rising edge. On return we
    // are just past the edge that took the byte and valid is still high.
    task automatic send_byte(input logic [7:0] b, input bit header_typed,
                             input logic [7:0] typed_hdr);
        int gap;
        bit took;
        gap = 0;
        if (!quiet_phase && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        bytes_in++;
        predict_packet_byte(b);
        if (pkt_done && header_typed) pending_bytes[hdr_pos].val = typed_hdr;
    endtask

    // Lower valid and wait until every predicted byte has come out, then let
    // the back end settle before anything else happens.
    task automatic drain_all();
        in_ch.valid <= 1'b0;
        wait (pending_bytes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write on an idle block; the model follows the same write.
    task automatic write_reg(input logic idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= LEN_W'(value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_PACKET_LENGTH) len_reg = value & 6'h3f;
        else interval_reg = value & 3'h7;
    endtask

    // Make sure both registers hold the wanted values, writing only on change.
    task automatic apply_config(input int len_val, input int int_val);
        if (len_val != len_reg || int_val != interval_reg) drain_all();
        if (len_val != len_reg) write_reg(REG_PACKET_LENGTH, len_val);
        if (int_val != interval_reg) write_reg(REG_KEYFRAME_INTERVAL, int_val);
    endtask

    // Build and send one packet of the current length.
    task automatic send_packet(input t_fill fill, input bit header_typed,
                               input logic [7:0] typed_hdr);
        int n, i;
        logic [7:0] b;
        n = eff_length();
        for (i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO:   b = 8'h00;
                FILL_ONES:   b = 8'hff;
                FILL_RAMP:   b = 8'(i * 9 + 3);
                FILL_NEAR:   b = prev_pkt[i] + 8'($urandom_range(0, 4)) - 8'd2;
                FILL_SPARSE: b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
                default:     b = 8'($urandom);
            endcase
            send_byte(b, header_typed, typed_hdr);
        end
    endtask

    t_row plan [13];

    initial begin
        int r, len_pick, int_pick, sent_packets;
        t_fill f;

        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready = 1'b0;
        for (r = 0; r < MaxPacketBytes; r++) begin
            prev_pkt[r] = 8'h00;
            cur_pkt[r]  = 8'h00;
        end
        for (r = 0; r < 4; r++) delta_seen[r] = 0;
        fill_idx = 0;
        sample_cnt = 0;
        len_reg = PACKET_LENGTH_RESET;
        interval_reg = KEYFRAME_INTERVAL_RESET;

        // Directed plan. A zero keyframe at reset length packs as a bitmap;
        // all-ones against zeros wins bytewise; a repeat gives zero deltas.
        // Zero length, oversize length and a zero interval are covered too.
        plan[0]  = '{32, 7, FILL_ZERO,   1'b1, 8'h20};
        plan[1]  = '{8,  7, FILL_ONES,   1'b1, 8'h09};
        plan[2]  = '{8,  7, FILL_ONES,   1'b1, 8'h2a};
        plan[3]  = '{8,  7, FILL_RAMP,   1'b0, 8'h00};
        plan[4]  = '{1,  7, FILL_RAND,   1'b0, 8'h00};
        plan[5]  = '{0,  7, FILL_RAND,   1'b0, 8'h00};
        plan[6]  = '{63, 7, FILL_NEAR,   1'b0, 8'h00};
        plan[7]  = '{2,  0, FILL_ZERO,   1'b0, 8'h00};
        plan[8]  = '{2,  0, FILL_ONES,   1'b1, 8'h00};
        plan[9]  = '{3,  1, FILL_RAND,   1'b0, 8'h00};
        plan[10] = '{5,  3, FILL_RAND,   1'b0, 8'h00};
        plan[11] = '{5,  3, FILL_NEAR,   1'b0, 8'h00};
        plan[12] = '{5,  3, FILL_SPARSE, 1'b0, 8'h00};

        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < 13; r++) begin
            apply_config(plan[r].len_cfg, plan[r].int_cfg);
            send_packet(plan[r].fill, plan[r].hdr_known, plan[r].hdr);
        end

        // Random part. Lengths are mostly short, with the full size now and
        // then; the registers change every few packets once the block is idle.
        // The closing full-size packet brings the total to about RANDOM_BYTES.
        sent_packets = 0;
        while (bytes_in < RANDOM_BYTES - 32) begin
            if (sent_packets % 4 == 0) begin
                r = $urandom_range(0, 99);
                if (r < 65) len_pick = $urandom_range(1, 8);
                else if (r < 85) len_pick = $urandom_range(9, 20);
                else if (r < 92) len_pick = 32;
                else if (r < 96) len_pick = 0;
                else len_pick = $urandom_range(33, 63);
                int_pick = $urandom_range(0, 7);
                apply_config(len_pick, int_pick);
            end
            f = t_fill'($urandom_range(0, 5));
            if ($urandom_range(0, 2) == 0) f = FILL_NEAR;
            send_packet(f, 1'b0, 8'h00);
            sent_packets++;
        end

        // Back to the reset values, then one last full-size random packet.
        apply_config(32, 7);
        send_packet(FILL_RAND, 1'b0, 8'h00);

        drain_all();
        $display("covered %0d bytes in, %0d bytes out, %0d packets, %0d bitmap packed",
                 bytes_in, bytes_out, packets_out, bitmap_pkts);
        $display("delta forms chosen: raw %0d, bytewise %0d, pairs %0d, full %0d",
                 delta_seen[0], delta_seen[1], delta_seen[2], delta_seen[3]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dbpc_pkg.sv
rtl/core/dbpc_in_if.sv
rtl/core/dbpc_out_if.sv
rtl/core/dbpc_front.sv
rtl/core/dbpc_queue.sv
rtl/core/dbpc_back.sv
rtl/core/delta_bitmap_packet_compressor_unit.sv
sim/delta_bitmap_packet_compressor_unit_tb.sv
